>>> rtl/sst_pkg.sv
// ---------------------------------------------------------------------------
// sst_pkg
// Shared types and codes for the sample size table insert block.
// ---------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int POS_W  = 11;
  localparam int SIZE_W = 32;
  localparam int PACK_W = 11;
  localparam int OCNT_W = 11;

  // Table action chosen for one item
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SET,
    ACT_ADD,
    ACT_EXPAND,
    ACT_INSERT
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DECIDE,
    S_FILL,
    S_SH_CHK,
    S_SH_WR,
    S_INS,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic dec_load;
    logic idx_zero;
    logic idx_held;
    logic idx_inc;
    logic idx_dec;
    logic wr_fill;
    logic wr_shift;
    logic wr_ins;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pack_gt1;
    logic div_busy;
    act_t act;
    logic idx_last;
    logic idx_ge_pos;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/sst_ram.sv
// ---------------------------------------------------------------------------
// sst_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/sst_ctrl.sv
// ---------------------------------------------------------------------------
// sst_ctrl
// Sequencer: divide, decide, fill or shift the size store, then report.
// ---------------------------------------------------------------------------
`default_nettype none

module sst_ctrl
  import sst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance and issue commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.pack_gt1) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.dec_load = 1'b1;
        case (sts.act)
          ACT_EXPAND: begin
            cmd.idx_zero = 1'b1;
            state_nxt    = S_FILL;
          end
          ACT_INSERT: begin
            cmd.idx_held = 1'b1;
            state_nxt    = S_SH_CHK;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FILL: begin
        cmd.wr_fill = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SH_CHK: begin
        // read of the entry below idx is in flight
        state_nxt = sts.idx_ge_pos ? S_SH_WR : S_INS;
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_nxt    = S_SH_CHK;
      end
      S_INS: begin
        cmd.wr_ins = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sst_dp.sv
// ---------------------------------------------------------------------------
// sst_dp
// Datapath: table registers, size store, bit-serial divider, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module sst_dp
  import sst_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic [POS_W-1:0]  in_pos,
  input  wire logic [SIZE_W-1:0] in_size,
  input  wire logic [PACK_W-1:0] in_pack,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output logic [1:0]             out_status,
  output logic [OCNT_W-1:0]      out_count,
  output logic                   out_expanded,
  input  wire cmd_t              cmd,
  output sts_t                   sts
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = ((CNT_W > PACK_W) ? CNT_W : PACK_W) + 1;
  localparam logic [SW-1:0] DEPTH_W = SW'(DEPTH);

  logic              cbm_r;
  logic [CNT_W-1:0]  held_r, idx_r;
  logic [SIZE_W-1:0] common_r, quo_r;
  logic              exp_r;
  logic [POS_W-1:0]  pos_r;
  logic [PACK_W-1:0] pack_r, rem_r;
  logic [5:0]        dcnt_r;
  logic [1:0]        stat_r;
  act_t              act_r;
  logic              ov_r;
  logic [1:0]        ost_r;
  logic [OCNT_W-1:0] ocnt_r;
  logic              oexp_r;

  // Effective pack count and wide copies for compares
  logic [PACK_W-1:0] pack_eff;
  logic [SW-1:0]     held_w, pos_w, pack_w, idx_w;
  logic [1:0]        stat_c;
  act_t              act_c;

  assign pack_eff = (pack_r == '0) ? PACK_W'(1) : pack_r;
  assign held_w   = SW'(held_r);
  assign pos_w    = SW'(pos_r);
  assign pack_w   = SW'(pack_eff);
  assign idx_w    = SW'(idx_r);

  // Choose status and action from the divided size
  always_comb begin
    stat_c = ST_OK;
    act_c  = ACT_NONE;
    if (pos_r == '0 || pos_w > held_w + SW'(1)) begin
      stat_c = ST_BAD;
    end else if (!exp_r) begin
      if (held_r == '0 && !cbm_r) begin
        if (pack_w > DEPTH_W) stat_c = ST_FULL;
        else act_c = ACT_SET;
      end else if (common_r == quo_r) begin
        if (held_w + pack_w > DEPTH_W) stat_c = ST_FULL;
        else act_c = ACT_ADD;
      end else if (pack_eff > PACK_W'(1)) begin
        stat_c = ST_UNSUP;
      end else if (held_w + SW'(1) > DEPTH_W) begin
        stat_c = ST_FULL;
      end else begin
        act_c = ACT_EXPAND;
      end
    end else if (held_w + SW'(1) > DEPTH_W) begin
      stat_c = ST_FULL;
    end else begin
      act_c = ACT_INSERT;
    end
  end

  // Restoring divide step: one quotient bit per cycle
  logic [PACK_W+1:0] trial;
  assign trial = {1'b0, rem_r, quo_r[SIZE_W-1]} - {2'b00, pack_r};

  // Size store
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [SIZE_W-1:0] wdata, rdata;
  logic [CNT_W-1:0]  idx_m1;
  logic [SW-1:0]     pos_m1;

  assign idx_m1 = idx_r - CNT_W'(1);
  assign pos_m1 = pos_w - SW'(1);
  assign raddr  = idx_m1[AW-1:0];

  always_comb begin
    we    = cmd.wr_fill | cmd.wr_shift | cmd.wr_ins;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    if (cmd.wr_fill) begin
      wdata = (idx_w + SW'(1) == pos_w) ? quo_r : common_r;
    end else if (cmd.wr_ins) begin
      waddr = pos_m1[AW-1:0];
      wdata = quo_r;
    end
  end

  sst_ram #(.WIDTH(SIZE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Table state after commit
  logic [CNT_W-1:0] held_nxt;
  always_comb begin
    held_nxt = held_r;
    case (act_r)
      ACT_SET:    held_nxt = CNT_W'(pack_eff);
      ACT_ADD:    held_nxt = CNT_W'(held_w + pack_w);
      ACT_EXPAND: held_nxt = held_r + CNT_W'(1);
      ACT_INSERT: held_nxt = held_r + CNT_W'(1);
      default:    held_nxt = held_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbm_r    <= 1'b0;
      held_r   <= '0;
      common_r <= '0;
      exp_r    <= 1'b0;
      dcnt_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) cbm_r <= cfg_wdata;
      if (cmd.div_start) begin
        dcnt_r <= 6'(SIZE_W);
      end else if (dcnt_r != '0) begin
        dcnt_r <= dcnt_r - 6'd1;
      end
      if (cmd.commit) begin
        held_r <= held_nxt;
        if (act_r == ACT_SET) common_r <= quo_r;
        if (act_r == ACT_EXPAND) begin
          common_r <= '0;
          exp_r    <= 1'b1;
        end
      end
      if (cmd.commit) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r  <= in_pos;
      quo_r  <= in_size;
      pack_r <= in_pack;
    end else if (dcnt_r != '0) begin
      if (!trial[PACK_W+1]) begin
        rem_r <= trial[PACK_W-1:0];
        quo_r <= {quo_r[SIZE_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[PACK_W-2:0], quo_r[SIZE_W-1]};
        quo_r <= {quo_r[SIZE_W-2:0], 1'b0};
      end
    end
    if (cmd.div_start) rem_r <= '0;
    if (cmd.dec_load) begin
      stat_r <= stat_c;
      act_r  <= act_c;
    end
    if (cmd.idx_zero) idx_r <= '0;
    else if (cmd.idx_held) idx_r <= held_r;
    else if (cmd.idx_inc) idx_r <= idx_r + CNT_W'(1);
    else if (cmd.idx_dec) idx_r <= idx_m1;
    if (cmd.commit) begin
      ost_r  <= stat_r;
      ocnt_r <= OCNT_W'(held_nxt);
      oexp_r <= exp_r | (act_r == ACT_EXPAND);
    end
  end

  assign sts.pack_gt1   = pack_r > PACK_W'(1);
  assign sts.div_busy   = dcnt_r != '0;
  assign sts.act        = act_c;
  assign sts.idx_last   = idx_r == held_r;
  assign sts.idx_ge_pos = idx_w >= pos_w;
  assign sts.out_free   = !ov_r || out_tready;

  assign out_tvalid   = ov_r;
  assign out_status   = ost_r;
  assign out_count    = ocnt_r;
  assign out_expanded = oexp_r;

endmodule

`default_nettype wire

>>> rtl/sample_size_table_insert.sv
// ---------------------------------------------------------------------------
// sample_size_table_insert
// Sample size table with insert-at-position requests, compact or expanded.
// ---------------------------------------------------------------------------
// One item is taken at a time. An item passes through the prepare, decide
// and done states, plus a bit-serial 32-bit divide when the pack count is
// above 1, plus a fill of held+1 store entries when the table expands (one
// store write a cycle), or a shift of entries from held down to pos for an
// insert in expanded mode, where each shifted entry needs a read and a
// write on the single-port-pair store. The result waits in an output
// register, so the next item may start while it is pending.
`default_nettype none

module sample_size_table_insert
  import sst_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,   // compact_box_mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,    // sample_position, sample_size, pack_count
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata    // status, count_after, is_expanded
);

  cmd_t              cmd;
  sts_t              sts;
  logic [1:0]        o_status;
  logic [OCNT_W-1:0] o_count;
  logic              o_exp;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sst_dp #(.DEPTH(DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_pos       (in_tdata[10:0]),
    .in_size      (in_tdata[42:11]),
    .in_pack      (in_tdata[53:43]),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_status   (o_status),
    .out_count    (o_count),
    .out_expanded (o_exp),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Pack the result item
  assign out_tdata = {2'b00, o_exp, o_count, o_status};

endmodule

`default_nettype wire
